[design/aae_pkg.sv]
// Shared types, widths and constants for the antenna azimuth/elevation block.
// Holds the CORDIC arctangent table. No dependencies.
package aae_pkg;

  // Number of CORDIC micro-rotations (hardware table holds 32 entries)
  localparam int CORDIC_STAGES = 24;
  localparam int NSTG = (CORDIC_STAGES > 32) ? 32 : CORDIC_STAGES;

  // Datapath widths
  localparam int XW = 64;   // CORDIC x/y
  localparam int ZW = 40;   // angle accumulator, 1e-9 degree units
  localparam int DW = 33;   // position offsets

  // Pipe stages from the offset registers to the final select
  localparam int PIPE_DEPTH = 2*NSTG + 4;

  // Register indexes of the configuration port
  localparam logic [1:0] REG_HOME_LAT = 2'd0;
  localparam logic [1:0] REG_HOME_LON = 2'd1;
  localparam logic [1:0] REG_MPD      = 2'd2;
  localparam logic [1:0] REG_TRIPOD   = 2'd3;

  localparam logic [17:0] MPD_RESET = 18'd111320;

  // Angle constants in nano-degrees
  localparam logic signed [ZW-1:0] HALF_TURN = 40'sd180000000000;
  localparam logic [ZW-1:0] HALF_CDEG = 40'd5000000;
  // Vertical scale: 10000 * K in Q16
  localparam logic [30:0] VSCALE = 31'd1079220000;
  // floor(n / 78125) == (n * RECIP) >> 48 for n < 2^31
  localparam logic [31:0] RECIP = 32'd3602879702;

  // Output limits (1/100 deg) and their rounding thresholds (nano-degrees)
  localparam logic [14:0] AZ_LIM = 15'd18000;
  localparam logic [14:0] EL_LIM = 15'd9000;
  localparam logic [ZW-1:0] AZ_THR = 40'd180005000000;
  localparam logic [ZW-1:0] EL_THR = 40'd90005000000;

  // Sideband carried along the azimuth chain
  typedef struct packed {
    logic                 nz;
    logic                 vpos;
    logic                 vneg;
    logic signed [XW-1:0] vs;
  } aside_t;

  // Sideband carried along the elevation chain
  typedef struct packed {
    logic hzero;
    logic vpos;
    logic vneg;
  } eside_t;

  // atan(2^-i) in nano-degrees
  function automatic logic signed [ZW-1:0] atan_ndeg(input logic [4:0] i);
    logic signed [ZW-1:0] a;
    unique case (i)
      5'd0:  a = 40'sd45000000000;
      5'd1:  a = 40'sd26565051177;
      5'd2:  a = 40'sd14036243468;
      5'd3:  a = 40'sd7125016349;
      5'd4:  a = 40'sd3576334375;
      5'd5:  a = 40'sd1789910608;
      5'd6:  a = 40'sd895173710;
      5'd7:  a = 40'sd447614171;
      5'd8:  a = 40'sd223810500;
      5'd9:  a = 40'sd111905677;
      5'd10: a = 40'sd55952892;
      5'd11: a = 40'sd27976453;
      5'd12: a = 40'sd13988227;
      5'd13: a = 40'sd6994114;
      5'd14: a = 40'sd3497057;
      5'd15: a = 40'sd1748528;
      5'd16: a = 40'sd874264;
      5'd17: a = 40'sd437132;
      5'd18: a = 40'sd218566;
      5'd19: a = 40'sd109283;
      5'd20: a = 40'sd54642;
      5'd21: a = 40'sd27321;
      5'd22: a = 40'sd13660;
      5'd23: a = 40'sd6830;
      5'd24: a = 40'sd3415;
      5'd25: a = 40'sd1708;
      5'd26: a = 40'sd854;
      5'd27: a = 40'sd427;
      5'd28: a = 40'sd213;
      5'd29: a = 40'sd107;
      5'd30: a = 40'sd53;
      default: a = 40'sd27;
    endcase
    return a;
  endfunction

endpackage

[design/aae_cell.sv]
// One registered CORDIC vectoring micro-rotation.
// Depends on aae_pkg.
module aae_cell import aae_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic [4:0]           shamt,
  input  logic signed [ZW-1:0] ang,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [XW-1:0] y_out,
  output logic signed [ZW-1:0] z_out
);

  logic signed [XW-1:0] xs, ys;
  logic signed [XW-1:0] x_nxt, y_nxt;
  logic signed [ZW-1:0] z_nxt;
  logic signed [XW-1:0] x_r, y_r;
  logic signed [ZW-1:0] z_r;

  // rotate toward y = 0
  always_comb begin
    xs = x_in >>> shamt;
    ys = y_in >>> shamt;
    if (!y_in[XW-1]) begin
      x_nxt = x_in + ys;
      y_nxt = y_in - xs;
      z_nxt = z_in + ang;
    end else begin
      x_nxt = x_in - ys;
      y_nxt = y_in + xs;
      z_nxt = z_in - ang;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x_out = x_r;
  assign y_out = y_r;
  assign z_out = z_r;

endmodule

[design/aae_cordic.sv]
// Vectoring CORDIC: half-plane pre-rotation followed by a chain of cells.
// Depends on aae_pkg and aae_cell.
module aae_cordic import aae_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [XW-1:0] x_in,
  input  logic signed [XW-1:0] y_in,
  output logic signed [XW-1:0] x_out,
  output logic signed [ZW-1:0] z_out
);

  logic signed [XW-1:0] xc [NSTG+1];
  logic signed [XW-1:0] yc [NSTG+1];
  logic signed [ZW-1:0] zc [NSTG+1];

  // left half plane: flip by a half turn
  always_comb begin
    if (x_in[XW-1]) begin
      xc[0] = -x_in;
      yc[0] = -y_in;
      zc[0] = y_in[XW-1] ? -HALF_TURN : HALF_TURN;
    end else begin
      xc[0] = x_in;
      yc[0] = y_in;
      zc[0] = '0;
    end
  end

  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    aae_cell u_cell (
      .clk   (clk),
      .en    (en),
      .shamt (5'(i)),
      .ang   (atan_ndeg(5'(i))),
      .x_in  (xc[i]),
      .y_in  (yc[i]),
      .z_in  (zc[i]),
      .x_out (xc[i+1]),
      .y_out (yc[i+1]),
      .z_out (zc[i+1])
    );
  end

  assign x_out = xc[NSTG];
  assign z_out = zc[NSTG];

endmodule

[design/aae_cdeg.sv]
// Nano-degrees to hundredths of a degree: round half away from zero, clamp.
// Depends on aae_pkg. Two register stages; result is combinational off the second.
module aae_cdeg import aae_pkg::*; (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [ZW-1:0] ndeg,
  input  logic [14:0]          lim,
  input  logic [ZW-1:0]        thr,
  output logic signed [15:0]   cdeg
);

  logic [ZW-1:0] mag, rnd;
  logic          neg1_r, big1_r, neg2_r, big2_r;
  logic [30:0]   n7_r;
  logic [62:0]   prod_r;
  logic [14:0]   q, qc;

  always_comb begin
    mag = ndeg[ZW-1] ? ZW'(-ndeg) : ZW'(ndeg);
    rnd = mag + HALF_CDEG;
  end

  // stage 1: magnitude, saturation check, drop the 2^7 factor of 1e7
  // stage 2: divide by 78125 through the reciprocal
  always_ff @(posedge clk) begin
    if (en) begin
      neg1_r <= ndeg[ZW-1];
      big1_r <= (mag >= thr);
      n7_r   <= rnd[37:7];
      neg2_r <= neg1_r;
      big2_r <= big1_r;
      prod_r <= 63'(n7_r * RECIP);
    end
  end

  always_comb begin
    q    = prod_r[62:48];
    qc   = big2_r ? lim : q;
    cdeg = neg2_r ? -$signed({1'b0, qc}) : $signed({1'b0, qc});
  end

endmodule

[design/antenna_azimuth_elevation.sv]
// Antenna pointing: azimuth and elevation from tracker to target.
// Depends on aae_pkg, aae_cordic, aae_cdeg.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one target fix: latitude,
//   longitude (1e-7 deg) and altitude (mm). Output channel (out_valid/
//   out_ready) returns azimuth and elevation in hundredths of a degree,
//   one result per transaction, in order.
//   Configuration: cfg_we writes cfg_wdata into register cfg_idx
//   (0 home latitude, 1 home longitude, 2 metres per degree, 3 tripod height)
//   in the same cycle; write only while no transaction is in flight.
//   Throughput: one transaction per cycle while in_ready is high. The
//   datapath is two chains of NSTG CORDIC cells (azimuth, then
//   elevation) plus offset, scaling and rounding stages.
//   Stall: the whole pipe advances together; an output register plus a
//   one-entry skid register keep in_ready high while one result waits.
//   in_ready drops once the skid is full.
//   Reset (rst_n low, synchronous) empties the pipe and loads register
//   defaults; in_ready is high the cycle after.
module antenna_azimuth_elevation import aae_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [30:0] in_target_lat,
  input  logic signed [31:0] in_target_lon,
  input  logic signed [31:0] in_target_alt_mm,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] out_azimuth_cdeg,
  output logic signed [14:0] out_elevation_cdeg,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_idx,
  input  logic [31:0]        cfg_wdata
);

  // configuration registers
  logic signed [30:0] home_lat_r;
  logic signed [31:0] home_lon_r;
  logic [17:0]        mpd_r;
  logic [15:0]        tripod_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_lat_r <= '0;
      home_lon_r <= '0;
      mpd_r      <= MPD_RESET;
      tripod_r   <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        REG_HOME_LAT: home_lat_r <= cfg_wdata[30:0];
        REG_HOME_LON: home_lon_r <= cfg_wdata;
        REG_MPD:      mpd_r      <= cfg_wdata[17:0];
        REG_TRIPOD:   tripod_r   <= cfg_wdata[15:0];
      endcase
    end
  end

  logic en;
  logic [PIPE_DEPTH-1:0] vld_r;

  // pipe valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (en) vld_r <= {vld_r[PIPE_DEPTH-2:0], in_valid};
  end

  // offsets from tracker
  logic signed [DW-1:0] dlat_r, dlon_r, vert_r;
  always_ff @(posedge clk) begin
    if (en) begin
      dlat_r <= DW'(in_target_lat) - DW'(home_lat_r);
      dlon_r <= DW'(in_target_lon) - DW'(home_lon_r);
      vert_r <= DW'(in_target_alt_mm) - $signed({17'b0, tripod_r});
    end
  end

  // vertical scaling onto the horizontal scale
  logic [DW-1:0] vm;
  logic [63:0]   vprod;
  logic [55:0]   vsh;
  aside_t        a_in;
  always_comb begin
    vm          = vert_r[DW-1] ? DW'(-vert_r) : DW'(vert_r);
    vprod       = 64'(vm * VSCALE);
    vsh         = vprod[63:8];
    a_in.nz     = (dlat_r != '0) || (dlon_r != '0);
    a_in.vpos   = !vert_r[DW-1] && (vert_r != '0);
    a_in.vneg   = vert_r[DW-1];
    a_in.vs     = vert_r[DW-1] ? -$signed({8'b0, vsh}) : $signed({8'b0, vsh});
  end

  // azimuth chain
  logic signed [XW-1:0] az_x;
  logic signed [ZW-1:0] az_z;
  aae_cordic u_cordic_az (
    .clk   (clk),
    .en    (en),
    .x_in  ({{15{dlat_r[DW-1]}}, dlat_r, 16'b0}),
    .y_in  ({{15{dlon_r[DW-1]}}, dlon_r, 16'b0}),
    .x_out (az_x),
    .z_out (az_z)
  );

  aside_t aside_r [NSTG];
  always_ff @(posedge clk) begin
    if (en) begin
      aside_r[0] <= a_in;
      for (int k = 1; k < NSTG; k++) aside_r[k] <= aside_r[k-1];
    end
  end

  // horizontal distance
  logic signed [XW-1:0] horiz_r, vs_r;
  eside_t               e_in;
  logic signed [ZW-1:0] az_ndeg;
  always_comb begin
    e_in.hzero = !aside_r[NSTG-1].nz || (az_x[XW-1:8] == '0) || (mpd_r == '0);
    e_in.vpos  = aside_r[NSTG-1].vpos;
    e_in.vneg  = aside_r[NSTG-1].vneg;
    az_ndeg    = aside_r[NSTG-1].nz ? az_z : '0;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      horiz_r <= $signed(64'(az_x[50:8] * mpd_r));
      vs_r    <= aside_r[NSTG-1].vs;
    end
  end

  // azimuth rounding
  logic signed [15:0] az_cdeg;
  aae_cdeg u_cdeg_az (
    .clk  (clk),
    .en   (en),
    .ndeg (az_ndeg),
    .lim  (AZ_LIM),
    .thr  (AZ_THR),
    .cdeg (az_cdeg)
  );

  // elevation chain
  logic signed [XW-1:0] el_x;
  logic signed [ZW-1:0] el_z;
  aae_cordic u_cordic_el (
    .clk   (clk),
    .en    (en),
    .x_in  (horiz_r),
    .y_in  (vs_r),
    .x_out (el_x),
    .z_out (el_z)
  );

  logic signed [15:0] el_cdeg;
  aae_cdeg u_cdeg_el (
    .clk  (clk),
    .en   (en),
    .ndeg (el_z),
    .lim  (EL_LIM),
    .thr  (EL_THR),
    .cdeg (el_cdeg)
  );

  // delay lines that keep azimuth and flags beside the elevation chain
  eside_t             eside_r [NSTG+3];
  logic signed [15:0] azd_r   [NSTG+1];
  always_ff @(posedge clk) begin
    if (en) begin
      eside_r[0] <= e_in;
      for (int k = 1; k < NSTG+3; k++) eside_r[k] <= eside_r[k-1];
      azd_r[0] <= az_cdeg;
      for (int k = 1; k < NSTG+1; k++) azd_r[k] <= azd_r[k-1];
    end
  end

  // final elevation select
  logic signed [15:0] res_az;
  logic signed [14:0] res_el;
  logic               pv;
  logic               el_x_unused;
  always_comb begin
    res_az = azd_r[NSTG];
    pv     = vld_r[PIPE_DEPTH-1];
    priority if (!eside_r[NSTG+2].hzero) res_el = el_cdeg[14:0];
    else if (eside_r[NSTG+2].vpos)      res_el = $signed(EL_LIM);
    else if (eside_r[NSTG+2].vneg)      res_el = -$signed(EL_LIM);
    else                                res_el = '0;
    el_x_unused = el_x[0];
  end

  // output register and skid
  logic               out_v_r, skid_v_r, take;
  logic signed [15:0] out_az_r, skid_az_r;
  logic signed [14:0] out_el_r, skid_el_r;

  assign en   = !skid_v_r;
  assign take = out_ready || !out_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r  <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (take) begin
      out_v_r  <= skid_v_r || pv;
      skid_v_r <= 1'b0;
    end else if (en && pv) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      out_az_r <= skid_v_r ? skid_az_r : res_az;
      out_el_r <= skid_v_r ? skid_el_r : res_el;
    end else if (en) begin
      skid_az_r <= res_az;
      skid_el_r <= res_el;
    end
  end

  assign in_ready           = en;
  assign out_valid          = out_v_r;
  assign out_azimuth_cdeg   = out_az_r;
  assign out_elevation_cdeg = out_el_r;

endmodule

[design/aae_checker.sv]
// Port-level checks for antenna_azimuth_elevation, bound to the top level.
// Depends on nothing beyond the top level's ports.
module aae_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] out_azimuth_cdeg,
  input logic signed [14:0] out_elevation_cdeg
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_azimuth_cdeg)
      && $stable(out_elevation_cdeg))
    else $error("result changed while stalled");

  // azimuth stays in range
  a_az_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_azimuth_cdeg >= -16'sd18000 && out_azimuth_cdeg <= 16'sd18000)
    else $error("azimuth out of range");

  // elevation stays in range
  a_el_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_elevation_cdeg >= -15'sd9000 && out_elevation_cdeg <= 15'sd9000)
    else $error("elevation out of range");

  // reset empties the output and opens the input
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid && in_ready)
    else $error("reset did not clear the pipe");

endmodule

bind antenna_azimuth_elevation aae_checker u_aae_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_ready           (in_ready),
  .out_valid          (out_valid),
  .out_ready          (out_ready),
  .out_azimuth_cdeg   (out_azimuth_cdeg),
  .out_elevation_cdeg (out_elevation_cdeg)
);

[tb/sv/tb_antenna_azimuth_elevation.sv]
`timescale 1ns / 100ps
// Self-checking testbench for antenna_azimuth_elevation: drives target fixes,
// predicts azimuth/elevation with a bit-true CORDIC model, checks every result.
// Depends on aae_pkg and the antenna_azimuth_elevation RTL.
module tb_antenna_azimuth_elevation import aae_pkg::*; ();

  // atan(2^-i) in nano-degrees
  longint ATAN_TBL [32] = '{
    64'sd45000000000, 64'sd26565051177, 64'sd14036243468, 64'sd7125016349,
    64'sd3576334375, 1789910608, 895173710, 447614171,
    223810500, 111905677, 55952892, 27976453,
    13988227, 6994114, 3497057, 1748528,
    874264, 437132, 218566, 109283,
    54642, 27321, 13660, 6830,
    3415, 1708, 854, 427,
    213, 107, 53, 27};

  typedef struct {
    logic signed [15:0] az;
    logic signed [14:0] el;
  } pointing_t;

  // Pointing predictor and queue of expected angles
  class pointing_scoreboard;
    logic signed [30:0] trk_lat;
    logic signed [31:0] trk_lon;
    logic [17:0]        mpd;
    logic [15:0]        tripod;
    pointing_t          pending[$];
    int                 errors;

    function void set_reg(logic [1:0] idx, logic [31:0] val);
      case (idx)
        REG_HOME_LAT: trk_lat = val[30:0];
        REG_HOME_LON: trk_lon = val;
        REG_MPD:      mpd = val[17:0];
        REG_TRIPOD:   tripod = val[15:0];
        default: ;
      endcase
    endfunction

    // Vectoring CORDIC, returns angle in nano-degrees
    function longint vector_angle(longint y, longint x, output longint xo);
      longint z;
      longint xs;
      longint ys;
      z = 0;
      if (x < 0) begin
        z = (y >= 0) ? 64'sd180000000000 : -64'sd180000000000;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < NSTG; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
        end else begin
          x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
        end
      end
      xo = x;
      return z;
    endfunction

    function longint ndeg_to_cdeg(longint nd, longint lim);
      longint unsigned mag;
      longint unsigned q;
      mag = (nd < 0) ? longint'(-nd) : nd;
      q = (mag + 64'd5000000) / 64'd10000000;
      if (q > lim) q = lim;
      return (nd < 0) ? -longint'(q) : longint'(q);
    endfunction

    function void note_fix(logic signed [30:0] lat, logic signed [31:0] lon,
                           logic signed [31:0] alt);
      longint dlat, dlon, vert, xfin, horiz, ang, vs, dummy;
      longint unsigned vm;
      pointing_t p;
      dlat = longint'(lat) - longint'(trk_lat);
      dlon = longint'(lon) - longint'(trk_lon);
      vert = longint'(alt) - longint'({1'b0, tripod});
      horiz = 0;
      p.az = 0;
      if (dlat != 0 || dlon != 0) begin
        ang = vector_angle(dlon * 65536, dlat * 65536, xfin);
        p.az = 16'(ndeg_to_cdeg(ang, 18000));
        horiz = (xfin >>> 8) * longint'({1'b0, mpd});
      end
      if (horiz == 0) begin
        p.el = (vert > 0) ? 15'sd9000 : ((vert < 0) ? -15'sd9000 : 15'sd0);
      end else begin
        vm = (vert < 0) ? longint'(-vert) : vert;
        vs = longint'((vm * 64'd10000 * 64'd107922) >> 8);
        ang = vector_angle((vert < 0) ? -vs : vs, horiz, dummy);
        p.el = 15'(ndeg_to_cdeg(ang, 9000));
      end
      pending.push_back(p);
    endfunction

    task report(string msg);
      $display("mismatch @%0t: %s", $time, msg);
      errors++;
    endtask

    task check_result(logic signed [15:0] az, logic signed [14:0] el);
      pointing_t p;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result az=%0d el=%0d", az, el));
        return;
      end
      p = pending.pop_front();
      if (az !== p.az) report($sformatf("azimuth %0d, expected %0d", az, p.az));
      if (el !== p.el) report($sformatf("elevation %0d, expected %0d", el, p.el));
    endtask
  endclass

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic signed [30:0] in_target_lat = '0;
  logic signed [31:0] in_target_lon = '0;
  logic signed [31:0] in_target_alt_mm = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic signed [15:0] out_azimuth_cdeg;
  logic signed [14:0] out_elevation_cdeg;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = REG_HOME_LAT;
  logic [31:0]        cfg_wdata = '0;

  pointing_scoreboard sb = new();
  bit idle_en = 1'b1;
  int hold_cycles = 0;

  antenna_azimuth_elevation dut (.*);

  always #5 clk = ~clk;

  // Hard limit on run time
  initial begin
    #5000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // Result side: random stalls, one long hold-off, check on each transaction
  initial begin
    forever begin
      @(negedge clk);
      if (hold_cycles > 0) begin
        out_ready = 1'b0;
        hold_cycles--;
      end else begin
        out_ready = !(idle_en && $urandom_range(99) < 17);
      end
      @(posedge clk);
      if (rst_n && out_valid && out_ready)
        sb.check_result(out_azimuth_cdeg, out_elevation_cdeg);
    end
  end

  task cfg_write(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_idx = idx;
    cfg_wdata = val;
    sb.set_reg(idx, val);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // Offer one fix; returns at the falling edge after its transaction
  task send_fix(logic signed [30:0] lat, logic signed [31:0] lon,
                logic signed [31:0] alt);
    while (idle_en && $urandom_range(99) < 17) begin
      in_valid = 1'b0;
      @(negedge clk);
    end
    in_valid = 1'b1;
    in_target_lat = lat;
    in_target_lon = lon;
    in_target_alt_mm = alt;
    forever begin
      @(posedge clk);
      if (in_ready) break;
    end
    sb.note_fix(lat, lon, alt);
    @(negedge clk);
  endtask

  task drain;
    int guard;
    guard = 0;
    in_valid = 1'b0;
    @(negedge clk);
    while (sb.pending.size() != 0 && guard < 100000) begin
      @(negedge clk);
      guard++;
    end
    repeat (2 * NSTG + 20) @(negedge clk);
  endtask

  // Random fix: anywhere, or near, on or in line with the tracker position
  task send_random;
    logic signed [30:0] lat;
    logic signed [31:0] lon;
    logic signed [31:0] alt;
    int mode;
    mode = $urandom_range(9);
    lat = 31'($urandom_range(1800000000) - 900000000);
    lon = $urandom_range(32'd3600000000) - 1800000000;
    alt = ($urandom_range(1)) ? $urandom : ($urandom_range(2000000) - 1000000);
    case (mode)
      6: begin lat = 31'($urandom); lon = $urandom; end
      7: begin
        lat = 31'(sb.trk_lat + ($urandom_range(2000) - 1000));
        lon = sb.trk_lon + ($urandom_range(2000) - 1000);
      end
      8: begin lat = sb.trk_lat; lon = sb.trk_lon; end
      9: if ($urandom_range(1)) lat = sb.trk_lat; else lon = sb.trk_lon;
      default: ;
    endcase
    send_fix(lat, lon, alt);
  endtask

  initial begin
    logic [31:0] phase_cfg [6][4];
    repeat (4) @(negedge clk);
    rst_n = 1'b1;
    sb.set_reg(REG_HOME_LAT, 0);
    sb.set_reg(REG_HOME_LON, 0);
    sb.set_reg(REG_MPD, 111320);
    sb.set_reg(REG_TRIPOD, 0);

    // Directed: axes, due south, coincident position, field extremes
    send_fix(0, 0, 0);
    send_fix(0, 0, 5000);
    send_fix(0, 0, -5000);
    send_fix(1000, 0, 100);
    send_fix(-1000, 0, 100);
    send_fix(0, 1000, -100);
    send_fix(0, -1000, 0);
    send_fix(-900000000, 0, 0);
    send_fix(900000000, 1800000000, 32'sh7fffffff);
    send_fix(-900000000, -1800000000, 32'sh80000000);
    send_fix(31'sh3fffffff, 32'sh7fffffff, 32'sh7fffffff);
    send_fix(31'sh40000000, 32'sh80000000, 32'sh80000000);
    send_fix(1, -1, 1);
    send_fix(-1, 1, -1);
    send_fix(123456, 654321, 10000000);
    drain();
    cfg_write(REG_MPD, 0);
    cfg_write(REG_TRIPOD, 65535);
    send_fix(5000, 5000, 100000);
    send_fix(5000, 5000, 0);
    send_fix(0, 0, 65535);
    send_fix(0, 0, 65534);
    drain();

    phase_cfg[0] = '{0, 0, 111320, 0};
    phase_cfg[1] = '{900000000, 1800000000, 262143, 65535};
    phase_cfg[2] = '{-900000000, -1800000000, 0, 0};
    phase_cfg[3] = '{32'h40000000, 32'h80000000, 1, 1};
    phase_cfg[4] = '{$urandom_range(1800000000) - 900000000,
                     $urandom_range(32'd3600000000) - 1800000000,
                     $urandom_range(262143), $urandom_range(65535)};
    phase_cfg[5] = '{$urandom, $urandom, $urandom, $urandom};

    for (int p = 0; p < 6; p++) begin
      cfg_write(REG_HOME_LAT, phase_cfg[p][0]);
      cfg_write(REG_HOME_LON, phase_cfg[p][1]);
      cfg_write(REG_MPD, phase_cfg[p][2]);
      cfg_write(REG_TRIPOD, phase_cfg[p][3]);
      for (int n = 0; n < 215; n++) begin
        // back-pressure burst, then a stretch with no idling
        if (p == 1 && n == 10) hold_cycles = 300;
        idle_en = !(p == 2 && n < 150);
        send_random();
      end
      idle_en = 1'b1;
      drain();
    end

    if (sb.pending.size() != 0)
      sb.report($sformatf("%0d results never arrived", sb.pending.size()));
    if (sb.errors == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end
endmodule

[antenna_azimuth_elevation.f]
design/aae_pkg.sv
design/aae_cell.sv
design/aae_cordic.sv
design/aae_cdeg.sv
design/antenna_azimuth_elevation.sv
design/aae_checker.sv
tb/sv/tb_antenna_azimuth_elevation.sv
